/* rtl/fastq_record_parser_assert.svh */
// Assertion macros shared by the parser RTL.
`ifndef FASTQ_RECORD_PARSER_ASSERT_SVH
`define FASTQ_RECORD_PARSER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define FRP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("parser check failed");

// Next-cycle implication, checked outside reset.
`define FRP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("parser check failed");

`endif

/* rtl/frp_pkg.sv */
// Shared types and constants of the FASTQ record parser.
`timescale 1ns / 1ps

package frp_pkg;

    localparam int MAX_READ_LEN_DEF = 1024;

    // Result kinds.
    localparam logic [2:0] KIND_ID   = 3'd0;
    localparam logic [2:0] KIND_SEQ  = 3'd1;
    localparam logic [2:0] KIND_QUAL = 3'd2;
    localparam logic [2:0] KIND_END  = 3'd3;
    localparam logic [2:0] KIND_ERR  = 3'd4;

    // Error codes.
    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_NO_AT    = 3'd1;
    localparam logic [2:0] ERR_EARLY    = 3'd2;
    localparam logic [2:0] ERR_NO_PLUS  = 3'd3;
    localparam logic [2:0] ERR_MISMATCH = 3'd4;

    // Characters.
    localparam logic [7:0] CH_AT    = 8'h40;
    localparam logic [7:0] CH_N     = 8'h4E;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LOW_A = 8'h61;
    localparam logic [7:0] CH_LOW_Z = 8'h7A;
    localparam logic [7:0] CASE_OFS = 8'h20;

    // One result, without the length field whose width follows the parameter.
    typedef struct packed {
        logic       valid;
        logic [2:0] kind;
        logic [7:0] value;
        logic [2:0] err;
    } t_result;

endpackage

/* rtl/frp_parser.sv */
// Parse state machine and read counters: one byte in, at most one result out.
`timescale 1ns / 1ps

module frp_parser #(
    parameter int MAX_READ_LEN = frp_pkg::MAX_READ_LEN_DEF,
    localparam int CW = $clog2(MAX_READ_LEN + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_advance,
    input  logic [7:0]        i_byte,
    input  logic              i_eoi,
    output frp_pkg::t_result  o_res,
    output logic [CW-1:0]     o_len
);

    localparam logic [3:0] PH_REC      = 4'd0;
    localparam logic [3:0] PH_SKIP     = 4'd1;
    localparam logic [3:0] PH_SKIP_EOL = 4'd2;
    localparam logic [3:0] PH_ID       = 4'd3;
    localparam logic [3:0] PH_ID_EOL   = 4'd4;
    localparam logic [3:0] PH_SEQ      = 4'd5;
    localparam logic [3:0] PH_SEQ_EOL  = 4'd6;
    localparam logic [3:0] PH_PLUS     = 4'd7;
    localparam logic [3:0] PH_PLUS_EOL = 4'd8;
    localparam logic [3:0] PH_QUAL     = 4'd9;

    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_READ_LEN);

    logic [3:0]    r_phase, n_phase;
    logic          r_first, n_first;
    logic [CW-1:0] r_seq_cnt, n_seq_cnt;
    logic [CW-1:0] r_qual_cnt, n_qual_cnt;
    logic          r_failed, n_failed;

    logic       nl;
    logic [7:0] seq_char;

    assign nl = (i_byte == frp_pkg::CH_LF) || (i_byte == frp_pkg::CH_CR);

    always_comb begin
        seq_char = i_byte;
        if (i_byte inside {[frp_pkg::CH_LOW_A:frp_pkg::CH_LOW_Z]}) begin
            seq_char = i_byte - frp_pkg::CASE_OFS;
        end
        if (seq_char == frp_pkg::CH_N) begin
            seq_char = frp_pkg::CH_A;
        end
    end

    always_comb begin
        n_phase    = r_phase;
        n_first    = r_first;
        n_seq_cnt  = r_seq_cnt;
        n_qual_cnt = r_qual_cnt;
        n_failed   = r_failed;
        o_res       = '0;
        o_res.kind  = frp_pkg::KIND_ERR;
        o_res.value = 8'd0;
        o_res.err   = frp_pkg::ERR_NONE;
        o_len       = '0;

        if (!r_failed) begin
            case (r_phase)
                PH_REC, PH_SKIP_EOL: begin
                    if (i_eoi) begin
                        if (r_first || r_phase == PH_SKIP_EOL) begin
                            o_res.valid = 1'b1;
                            o_res.err   = frp_pkg::ERR_EARLY;
                        end
                    end else if (!nl) begin
                        if (i_byte == frp_pkg::CH_AT) begin
                            n_first    = 1'b0;
                            n_seq_cnt  = '0;
                            n_qual_cnt = '0;
                            n_phase    = PH_ID;
                        end else if (r_first && r_phase == PH_REC) begin
                            n_phase = PH_SKIP;
                        end else begin
                            o_res.valid = 1'b1;
                            o_res.err   = frp_pkg::ERR_NO_AT;
                        end
                    end
                end
                PH_SKIP, PH_PLUS: begin
                    if (i_eoi) begin
                        o_res.valid = 1'b1;
                        o_res.err   = frp_pkg::ERR_EARLY;
                    end else if (nl) begin
                        n_phase = (r_phase == PH_SKIP) ? PH_SKIP_EOL : PH_PLUS_EOL;
                    end
                end
                PH_ID: begin
                    if (i_eoi) begin
                        o_res.valid = 1'b1;
                        o_res.err   = frp_pkg::ERR_EARLY;
                    end else if (nl) begin
                        n_phase = PH_ID_EOL;
                    end else if (i_byte != frp_pkg::CH_AT) begin
                        o_res.valid = 1'b1;
                        o_res.kind  = frp_pkg::KIND_ID;
                        o_res.value = i_byte;
                    end
                end
                PH_ID_EOL, PH_SEQ: begin
                    if (i_eoi) begin
                        o_res.valid = 1'b1;
                        o_res.err   = frp_pkg::ERR_EARLY;
                    end else if (nl) begin
                        if (r_phase == PH_SEQ) begin
                            n_phase = PH_SEQ_EOL;
                        end
                    end else if (r_seq_cnt >= MAX_CNT) begin
                        o_res.valid = 1'b1;
                        o_res.err   = frp_pkg::ERR_MISMATCH;
                    end else begin
                        n_seq_cnt   = r_seq_cnt + 1'b1;
                        n_phase     = PH_SEQ;
                        o_res.valid = 1'b1;
                        o_res.kind  = frp_pkg::KIND_SEQ;
                        o_res.value = seq_char;
                    end
                end
                PH_SEQ_EOL: begin
                    if (i_eoi) begin
                        o_res.valid = 1'b1;
                        o_res.err   = frp_pkg::ERR_EARLY;
                    end else if (!nl) begin
                        if (i_byte == frp_pkg::CH_PLUS) begin
                            n_phase = PH_PLUS;
                        end else begin
                            o_res.valid = 1'b1;
                            o_res.err   = frp_pkg::ERR_NO_PLUS;
                        end
                    end
                end
                PH_PLUS_EOL, PH_QUAL: begin
                    if (i_eoi && r_phase == PH_PLUS_EOL) begin
                        o_res.valid = 1'b1;
                        o_res.err   = frp_pkg::ERR_EARLY;
                    end else if (nl && r_phase == PH_PLUS_EOL) begin
                        // Extra line breaks after the plus line are skipped.
                    end else if (i_eoi || nl) begin
                        // The quality line ends the record.
                        o_res.valid = 1'b1;
                        if (r_qual_cnt != r_seq_cnt) begin
                            o_res.err = frp_pkg::ERR_MISMATCH;
                        end else begin
                            o_res.kind = frp_pkg::KIND_END;
                            o_len      = r_seq_cnt;
                            n_phase    = PH_REC;
                        end
                    end else if (r_qual_cnt >= MAX_CNT) begin
                        o_res.valid = 1'b1;
                        o_res.err   = frp_pkg::ERR_MISMATCH;
                    end else begin
                        n_qual_cnt  = r_qual_cnt + 1'b1;
                        n_phase     = PH_QUAL;
                        o_res.valid = 1'b1;
                        o_res.kind  = frp_pkg::KIND_QUAL;
                        o_res.value = i_byte;
                    end
                end
                default: begin
                    n_phase = PH_REC;
                end
            endcase
            if (o_res.valid && o_res.kind == frp_pkg::KIND_ERR) begin
                n_failed = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_REC;
            r_first    <= 1'b1;
            r_seq_cnt  <= '0;
            r_qual_cnt <= '0;
            r_failed   <= 1'b0;
        end else if (i_advance) begin
            r_phase    <= n_phase;
            r_first    <= n_first;
            r_seq_cnt  <= n_seq_cnt;
            r_qual_cnt <= n_qual_cnt;
            r_failed   <= n_failed;
        end
    end

endmodule

/* rtl/frp_out_reg.sv */
// Result register that holds one result until the consumer takes it.
`timescale 1ns / 1ps

module frp_out_reg #(
    parameter int LW = 11
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  frp_pkg::t_result i_res,
    input  logic [LW-1:0]    i_len,
    output logic             o_space,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [2:0]       o_kind,
    output logic [7:0]       o_value,
    output logic [LW-1:0]    o_read_length,
    output logic [2:0]       o_error_code
);

    logic          r_valid;
    logic [2:0]    r_kind;
    logic [7:0]    r_value;
    logic [LW-1:0] r_len;
    logic [2:0]    r_err;
    logic          take;

    // The register frees up in the same cycle its request is taken.
    assign o_space = !r_valid || i_ready;
    assign take    = i_load && o_space && i_res.valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_space) begin
            r_valid <= take;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_kind  <= i_res.kind;
            r_value <= i_res.value;
            r_len   <= i_len;
            r_err   <= i_res.err;
        end
    end

    assign o_valid       = r_valid;
    assign o_kind        = r_kind;
    assign o_value       = r_value;
    assign o_read_length = r_len;
    assign o_error_code  = r_err;

endmodule

/* rtl/fastq_record_parser.sv */
// Top level of the FASTQ record parser: input register, parser and result register.
`timescale 1ns / 1ps
`include "fastq_record_parser_assert.svh"

// Streams FASTQ text one byte per request and returns identifier, sequence and
// quality bytes, a record-end request with the sequence length, or a single
// error after which the block stays silent until reset. A byte is taken every
// cycle when the output side keeps up; each byte is held in the input register
// and its result in the result register. The phase update and the two read
// counters lie between those registers. Bytes that produce no result (line
// breaks, the plus line, dropped '@') still pass through the input register.
module fastq_record_parser #(
    parameter int MAX_READ_LEN = frp_pkg::MAX_READ_LEN_DEF,
    localparam int CW = $clog2(MAX_READ_LEN + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [7:0]    i_byte_in,
    input  logic          i_end_of_input,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [2:0]    o_kind,
    output logic [7:0]    o_value,
    output logic [CW-1:0] o_read_length,
    output logic [2:0]    o_error_code
);

    logic             r_in_valid;
    logic [7:0]       r_byte;
    logic             r_eoi;
    logic             out_space;
    logic             advance;
    frp_pkg::t_result res;
    logic [CW-1:0]    res_len;

    assign advance = r_in_valid && out_space;
    assign o_ready = !r_in_valid || out_space;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_byte <= i_byte_in;
            r_eoi  <= i_end_of_input;
        end
    end

    frp_parser #(
        .MAX_READ_LEN(MAX_READ_LEN)
    ) u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_byte    (r_byte),
        .i_eoi     (r_eoi),
        .o_res     (res),
        .o_len     (res_len)
    );

    frp_out_reg #(
        .LW(CW)
    ) u_out_reg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (advance),
        .i_res         (res),
        .i_len         (res_len),
        .o_space       (out_space),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_kind        (o_kind),
        .o_value       (o_value),
        .o_read_length (o_read_length),
        .o_error_code  (o_error_code)
    );

    // Nothing follows an error once it has been taken.
    `FRP_ASSERT_NEXT(a_silent_after_error, i_clk, i_rst_n, o_valid && i_ready && o_kind == frp_pkg::KIND_ERR, !o_valid)

    // An error code is carried by error requests and by nothing else.
    `FRP_ASSERT_NOW(a_err_code_kind, i_clk, i_rst_n, o_valid, (o_kind == frp_pkg::KIND_ERR) == (o_error_code != frp_pkg::ERR_NONE))

    // The length field is zero except on record end.
    `FRP_ASSERT_NOW(a_len_only_at_end, i_clk, i_rst_n, o_valid && o_kind != frp_pkg::KIND_END, o_read_length == '0)

    // Back pressure on the input only comes from a held byte.
    `FRP_ASSERT_NOW(a_ready_when_empty, i_clk, i_rst_n, !r_in_valid, o_ready)

endmodule
